>>> hw/rtl/sdp_pkg.sv
// Package for the stereo disparity to point block.
// Holds register indexes, reset values, limits and the shared types.
// No dependencies.
package sdp_pkg;

    // Defaults for the top-level parameters.
    localparam int COORD_BITS_DEF     = 12;
    localparam int DISP_FRAC_BITS_DEF = 4;

    // Fixed widths of the configuration port and the fixed-point formats.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_FRAC   = 4;
    localparam int BASE_FRAC  = 16;
    localparam int OUT_FRAC   = 8;
    localparam int DEN_SHIFT  = CFG_FRAC + BASE_FRAC - OUT_FRAC;
    localparam int DISP_W     = 12;
    localparam int INTEN_W    = 12;
    localparam int CTR_W      = 16;
    localparam int FOCAL_W    = 16;
    localparam int BASE_W     = 20;
    localparam int SIZE_W     = 13;
    localparam int XY_W       = 24;
    localparam int Z_W        = 23;

    // Saturation limits of the Q15.8 coordinates.
    localparam logic [XY_W-1:0] POS_MAX = 24'h7FFFFF;
    localparam logic [XY_W-1:0] NEG_MAX = 24'h800000;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASELINE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CALIBRATED = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DECIMATION = 3'd7;

    // Register reset values.
    localparam logic [CTR_W-1:0]   RST_CENTER_X = 16'd5075;
    localparam logic [CTR_W-1:0]   RST_CENTER_Y = 16'd3733;
    localparam logic [FOCAL_W-1:0] RST_FOCAL    = 16'd4920;
    localparam logic [BASE_W-1:0]  RST_BASELINE = 20'd36543;
    localparam logic [SIZE_W-1:0]  RST_WIDTH    = 13'd640;
    localparam logic [SIZE_W-1:0]  RST_HEIGHT   = 13'd480;
    localparam logic [1:0]         RST_DECIM    = 2'd2;

    // Calibration registers as seen by the front end.
    typedef struct packed {
        logic [CTR_W-1:0]   center_x;
        logic [CTR_W-1:0]   center_y;
        logic [FOCAL_W-1:0] focal;
        logic [BASE_W-1:0]  baseline;
        logic [SIZE_W-1:0]  width;
        logic [SIZE_W-1:0]  height;
        logic               calibrated;
        logic [1:0]         decim;
    } t_cfg;

    // Per-word flags that travel with the numerators.
    typedef struct packed {
        logic depth_ok;
        logic neg_x;
        logic neg_y;
    } t_flags;

    // One finished point.
    typedef struct packed {
        logic [XY_W-1:0]    x;
        logic [XY_W-1:0]    y;
        logic [Z_W-1:0]     z;
        logic [INTEN_W-1:0] intensity;
        logic               depth_valid;
    } t_point;

endpackage

>>> hw/rtl/sdp_queue.sv
// Small register-based queue used between the parts of the block.
// Depends on nothing; DEPTH must be a power of two.
module sdp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [AW:0]      r_count;
    logic             w_wr;
    logic             w_rd;

    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (AW+1)'(DEPTH))
        else $error("queue count beyond depth");
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && i_push && !i_pop) |=> o_full && $stable(r_wr_ptr))
        else $error("queue overrun");
    a_pop_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rd && !w_wr) |=> (r_count == $past(r_count) - 1'b1))
        else $error("queue count not decremented on read");

endmodule

>>> hw/rtl/sdp_front.sv
// Front end: accepts pixels, drops those off the image or grid or taken while
// not calibrated, and forms the three numerators. Depends on sdp_pkg.
module sdp_front #(
    parameter int COORD_BITS     = 12,
    parameter int DISP_FRAC_BITS = 4,
    parameter int NUM_W          = 28
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sdp_pkg::t_cfg              i_cfg,
    input  logic                       i_push,
    output logic                       o_full,
    input  logic [COORD_BITS-1:0]      i_column,
    input  logic [COORD_BITS-1:0]      i_row,
    input  logic [sdp_pkg::DISP_W-1:0] i_disparity,
    input  logic [sdp_pkg::INTEN_W-1:0] i_intensity,
    output logic                       o_push,
    input  logic                       i_full,
    output sdp_pkg::t_flags            o_flags,
    output logic [NUM_W-1:0]           o_num_x,
    output logic [NUM_W-1:0]           o_num_y,
    output logic [NUM_W-1:0]           o_num_z,
    output logic [sdp_pkg::DISP_W-1:0] o_disp,
    output logic [sdp_pkg::INTEN_W-1:0] o_intensity
);
    import sdp_pkg::*;

    localparam int CMP_W  = ((COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W) + 1;
    localparam int POS_W  = COORD_BITS + CFG_FRAC;
    localparam int MAG_W  = (POS_W > CTR_W) ? POS_W : CTR_W;
    localparam int PROD_W = MAG_W + BASE_W;
    localparam int SHIFT  = DEN_SHIFT - DISP_FRAC_BITS;
    localparam int ZP_W   = BASE_W + FOCAL_W;

    logic               w_accept;
    logic               w_adv1;
    logic               w_adv2;
    logic               w_keep;
    logic [CMP_W-1:0]   w_u;
    logic [CMP_W-1:0]   w_v;
    logic [CMP_W-1:0]   w_dx;
    logic [CMP_W-1:0]   w_dy;
    logic [2:0]         w_mask;
    logic [MAG_W-1:0]   w_pos_x;
    logic [MAG_W-1:0]   w_pos_y;
    logic [MAG_W-1:0]   w_ctr_x;
    logic [MAG_W-1:0]   w_ctr_y;
    logic [PROD_W-1:0]  w_prod_x;
    logic [PROD_W-1:0]  w_prod_y;
    logic [ZP_W-1:0]    w_prod_z;
    logic [PROD_W-1:0]  w_prod_z_ext;

    logic               r_v1;
    logic [MAG_W-1:0]   r_mag_x;
    logic [MAG_W-1:0]   r_mag_y;
    t_flags             r_fl1;
    logic [DISP_W-1:0]  r_d1;
    logic [INTEN_W-1:0] r_i1;

    logic               r_v2;
    t_flags             r_fl2;
    logic [NUM_W-1:0]   r_nx;
    logic [NUM_W-1:0]   r_ny;
    logic [NUM_W-1:0]   r_nz;
    logic [DISP_W-1:0]  r_d2;
    logic [INTEN_W-1:0] r_i2;

    // Pipeline flow: stage two drains into the queue, stage one into stage two.
    assign w_adv2   = !r_v2 || !i_full;
    assign w_adv1   = !r_v1 || w_adv2;
    assign o_full   = !w_adv1;
    assign w_accept = i_push && w_adv1;

    // Classification: calibrated, inside the image and on the decimation grid.
    assign w_u    = CMP_W'(i_column);
    assign w_v    = CMP_W'(i_row);
    assign w_dx   = CMP_W'(i_cfg.width) - CMP_W'(1) - w_u;
    assign w_dy   = CMP_W'(i_cfg.height) - CMP_W'(1) - w_v;
    assign w_mask = 3'((4'd1 << i_cfg.decim) - 4'd1);
    assign w_keep = i_cfg.calibrated
                 && (w_u < CMP_W'(i_cfg.width)) && (w_v < CMP_W'(i_cfg.height))
                 && ((w_dx[2:0] & w_mask) == 3'd0) && ((w_dy[2:0] & w_mask) == 3'd0);

    // Pixel position in Q4 against the principal point.
    assign w_pos_x = MAG_W'({i_column, {CFG_FRAC{1'b0}}});
    assign w_pos_y = MAG_W'({i_row, {CFG_FRAC{1'b0}}});
    assign w_ctr_x = MAG_W'(i_cfg.center_x);
    assign w_ctr_y = MAG_W'(i_cfg.center_y);

    // Stage one: offsets from the principal point with their signs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_adv1) begin
            r_v1 <= w_accept && w_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_fl1.neg_x    <= w_pos_x < w_ctr_x;
            r_fl1.neg_y    <= w_pos_y < w_ctr_y;
            r_fl1.depth_ok <= (i_disparity != '0);
            r_mag_x        <= (w_pos_x < w_ctr_x) ? w_ctr_x - w_pos_x : w_pos_x - w_ctr_x;
            r_mag_y        <= (w_pos_y < w_ctr_y) ? w_ctr_y - w_pos_y : w_pos_y - w_ctr_y;
            r_d1           <= i_disparity;
            r_i1           <= i_intensity;
        end
    end

    // Products with the baseline; the common power of two is removed here.
    assign w_prod_x     = PROD_W'(r_mag_x) * PROD_W'(i_cfg.baseline);
    assign w_prod_y     = PROD_W'(r_mag_y) * PROD_W'(i_cfg.baseline);
    assign w_prod_z     = ZP_W'(i_cfg.baseline) * ZP_W'(i_cfg.focal);
    assign w_prod_z_ext = PROD_W'(w_prod_z);

    // Stage two: registered numerators.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_adv2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            r_fl2 <= r_fl1;
            r_nx  <= w_prod_x[PROD_W-1:SHIFT];
            r_ny  <= w_prod_y[PROD_W-1:SHIFT];
            r_nz  <= w_prod_z_ext[PROD_W-1:SHIFT];
            r_d2  <= r_d1;
            r_i2  <= r_i1;
        end
    end

    assign o_push      = r_v2;
    assign o_flags     = r_fl2;
    assign o_num_x     = r_nx;
    assign o_num_y     = r_ny;
    assign o_num_z     = r_nz;
    assign o_disp      = r_d2;
    assign o_intensity = r_i2;

endmodule

>>> hw/rtl/sdp_back.sv
// Back end: three pipelined restoring dividers, one quotient bit per stage,
// then saturation into a finished point. Depends on sdp_pkg.
module sdp_back #(
    parameter int NUM_W = 28
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  sdp_pkg::t_flags             i_flags,
    input  logic [NUM_W-1:0]            i_num_x,
    input  logic [NUM_W-1:0]            i_num_y,
    input  logic [NUM_W-1:0]            i_num_z,
    input  logic [sdp_pkg::DISP_W-1:0]  i_disp,
    input  logic [sdp_pkg::INTEN_W-1:0] i_intensity,
    output logic                        o_valid,
    output sdp_pkg::t_point             o_point
);
    import sdp_pkg::*;

    localparam int R_W = DISP_W + NUM_W;

    logic               r_vld  [NUM_W+1];
    t_flags             r_fl   [NUM_W+1];
    logic [R_W-1:0]     r_ax   [NUM_W+1];
    logic [R_W-1:0]     r_ay   [NUM_W+1];
    logic [R_W-1:0]     r_az   [NUM_W+1];
    logic [DISP_W-1:0]  r_d    [NUM_W+1];
    logic [INTEN_W-1:0] r_int  [NUM_W+1];

    logic [NUM_W-1:0]   w_qx;
    logic [NUM_W-1:0]   w_qy;
    logic [NUM_W-1:0]   w_qz;
    logic [XY_W-1:0]    w_sx;
    logic [XY_W-1:0]    w_sy;
    logic [Z_W-1:0]     w_sz;

    // Entry stage: remainder starts at zero above the numerator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fl[0]  <= i_flags;
            r_ax[0]  <= R_W'(i_num_x);
            r_ay[0]  <= R_W'(i_num_y);
            r_az[0]  <= R_W'(i_num_z);
            r_d[0]   <= i_disp;
            r_int[0] <= i_intensity;
        end
    end

    // One divide step per stage for each of the three quotients.
    for (genvar k = 0; k < NUM_W; k++) begin : g_step
        logic [DISP_W:0] w_tx;
        logic [DISP_W:0] w_ty;
        logic [DISP_W:0] w_tz;
        logic [DISP_W:0] w_dd;
        logic            w_bx;
        logic            w_by;
        logic            w_bz;
        logic [DISP_W:0] w_rx;
        logic [DISP_W:0] w_ry;
        logic [DISP_W:0] w_rz;

        assign w_dd = {1'b0, r_d[k]};
        assign w_tx = r_ax[k][R_W-1:NUM_W-1];
        assign w_ty = r_ay[k][R_W-1:NUM_W-1];
        assign w_tz = r_az[k][R_W-1:NUM_W-1];
        assign w_bx = (w_tx >= w_dd);
        assign w_by = (w_ty >= w_dd);
        assign w_bz = (w_tz >= w_dd);
        assign w_rx = w_bx ? w_tx - w_dd : w_tx;
        assign w_ry = w_by ? w_ty - w_dd : w_ty;
        assign w_rz = w_bz ? w_tz - w_dd : w_tz;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_fl[k+1]  <= r_fl[k];
                r_d[k+1]   <= r_d[k];
                r_int[k+1] <= r_int[k];
                if (NUM_W > 1) begin
                    r_ax[k+1] <= R_W'({w_rx[DISP_W-1:0], r_ax[k][NUM_W-2:0], w_bx});
                    r_ay[k+1] <= R_W'({w_ry[DISP_W-1:0], r_ay[k][NUM_W-2:0], w_by});
                    r_az[k+1] <= R_W'({w_rz[DISP_W-1:0], r_az[k][NUM_W-2:0], w_bz});
                end else begin
                    r_ax[k+1] <= R_W'({w_rx[DISP_W-1:0], w_bx});
                    r_ay[k+1] <= R_W'({w_ry[DISP_W-1:0], w_by});
                    r_az[k+1] <= R_W'({w_rz[DISP_W-1:0], w_bz});
                end
            end
        end
    end

    // Saturation of the quotients.
    assign w_qx = r_ax[NUM_W][NUM_W-1:0];
    assign w_qy = r_ay[NUM_W][NUM_W-1:0];
    assign w_qz = r_az[NUM_W][NUM_W-1:0];

    always_comb begin
        if (r_fl[NUM_W].neg_x) begin
            w_sx = (w_qx > NUM_W'(NEG_MAX)) ? NEG_MAX : XY_W'(~w_qx[XY_W-1:0] + 1'b1);
        end else begin
            w_sx = (w_qx > NUM_W'(POS_MAX)) ? POS_MAX : w_qx[XY_W-1:0];
        end
        if (r_fl[NUM_W].neg_y) begin
            w_sy = (w_qy > NUM_W'(NEG_MAX)) ? NEG_MAX : XY_W'(~w_qy[XY_W-1:0] + 1'b1);
        end else begin
            w_sy = (w_qy > NUM_W'(POS_MAX)) ? POS_MAX : w_qy[XY_W-1:0];
        end
        w_sz = (w_qz > NUM_W'(POS_MAX)) ? POS_MAX[Z_W-1:0] : w_qz[Z_W-1:0];
    end

    // A zero disparity gives a point at the origin flagged invalid.
    always_comb begin
        o_point.intensity   = r_int[NUM_W];
        o_point.depth_valid = r_fl[NUM_W].depth_ok;
        if (r_fl[NUM_W].depth_ok) begin
            o_point.x = w_sx;
            o_point.y = w_sy;
            o_point.z = w_sz;
        end else begin
            o_point.x = '0;
            o_point.y = '0;
            o_point.z = '0;
        end
    end

    assign o_valid = r_vld[NUM_W];

endmodule

>>> hw/rtl/stereo_disparity_to_point.sv
// Top level of the stereo disparity to point block.
// Depends on sdp_pkg, sdp_queue, sdp_front and sdp_back.
//
// Each accepted pixel that is calibrated, inside the image and on the
// decimation grid becomes one point; others are dropped. The block takes one
// pixel per clock while full is low. A kept pixel passes the front-end
// stages, the work queue and the divider pipeline, which retires one quotient
// bit per stage for x, y and z at once, before it reaches the result queue.
// Points leave in input order through a two-word result queue; a four-word
// queue between the front end and the dividers lets each side stall alone.
module stereo_disparity_to_point #(
    parameter int COORD_BITS     = sdp_pkg::COORD_BITS_DEF,
    parameter int DISP_FRAC_BITS = sdp_pkg::DISP_FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [sdp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sdp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            push,
    output logic                            full,
    input  logic [COORD_BITS-1:0]           i_column,
    input  logic [COORD_BITS-1:0]           i_row,
    input  logic [sdp_pkg::DISP_W-1:0]      i_disparity,
    input  logic [sdp_pkg::INTEN_W-1:0]     i_intensity,
    output logic                            empty,
    input  logic                            pop,
    output logic [sdp_pkg::XY_W-1:0]        o_point_x,
    output logic [sdp_pkg::XY_W-1:0]        o_point_y,
    output logic [sdp_pkg::Z_W-1:0]         o_point_z,
    output logic [sdp_pkg::INTEN_W-1:0]     o_point_intensity,
    output logic                            o_depth_valid
);
    import sdp_pkg::*;

    localparam int POS_W  = COORD_BITS + CFG_FRAC;
    localparam int MAG_W  = (POS_W > CTR_W) ? POS_W : CTR_W;
    localparam int NUM_W  = MAG_W + BASE_W - (DEN_SHIFT - DISP_FRAC_BITS);
    localparam int MID_W  = $bits(t_flags) + 3 * NUM_W + DISP_W + INTEN_W;

    t_cfg               r_cfg;
    logic               w_mid_push;
    logic               w_mid_full;
    logic               w_mid_empty;
    logic               w_mid_pop;
    logic [MID_W-1:0]   w_mid_in;
    logic [MID_W-1:0]   w_mid_out;
    t_flags             w_f_flags;
    logic [NUM_W-1:0]   w_f_nx;
    logic [NUM_W-1:0]   w_f_ny;
    logic [NUM_W-1:0]   w_f_nz;
    logic [DISP_W-1:0]  w_f_d;
    logic [INTEN_W-1:0] w_f_i;
    t_flags             w_b_flags;
    logic [NUM_W-1:0]   w_b_nx;
    logic [NUM_W-1:0]   w_b_ny;
    logic [NUM_W-1:0]   w_b_nz;
    logic [DISP_W-1:0]  w_b_d;
    logic [INTEN_W-1:0] w_b_i;
    logic               w_back_en;
    logic               w_back_valid;
    t_point             w_back_point;
    logic               w_out_full;
    t_point             w_head;

    // Configuration registers, masked to their widths.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x   <= RST_CENTER_X;
            r_cfg.center_y   <= RST_CENTER_Y;
            r_cfg.focal      <= RST_FOCAL;
            r_cfg.baseline   <= RST_BASELINE;
            r_cfg.width      <= RST_WIDTH;
            r_cfg.height     <= RST_HEIGHT;
            r_cfg.calibrated <= 1'b0;
            r_cfg.decim      <= RST_DECIM;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_CENTER_X:   r_cfg.center_x   <= i_cfg_data[CTR_W-1:0];
                REG_CENTER_Y:   r_cfg.center_y   <= i_cfg_data[CTR_W-1:0];
                REG_FOCAL:      r_cfg.focal      <= i_cfg_data[FOCAL_W-1:0];
                REG_BASELINE:   r_cfg.baseline   <= i_cfg_data[BASE_W-1:0];
                REG_WIDTH:      r_cfg.width      <= i_cfg_data[SIZE_W-1:0];
                REG_HEIGHT:     r_cfg.height     <= i_cfg_data[SIZE_W-1:0];
                REG_CALIBRATED: r_cfg.calibrated <= i_cfg_data[0];
                REG_DECIMATION: r_cfg.decim      <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Front end.
    sdp_front #(
        .COORD_BITS     (COORD_BITS),
        .DISP_FRAC_BITS (DISP_FRAC_BITS),
        .NUM_W          (NUM_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_push      (push),
        .o_full      (full),
        .i_column    (i_column),
        .i_row       (i_row),
        .i_disparity (i_disparity),
        .i_intensity (i_intensity),
        .o_push      (w_mid_push),
        .i_full      (w_mid_full),
        .o_flags     (w_f_flags),
        .o_num_x     (w_f_nx),
        .o_num_y     (w_f_ny),
        .o_num_z     (w_f_nz),
        .o_disp      (w_f_d),
        .o_intensity (w_f_i)
    );

    // Work queue between front and back.
    assign w_mid_in = {w_f_flags, w_f_nx, w_f_ny, w_f_nz, w_f_d, w_f_i};
    assign {w_b_flags, w_b_nx, w_b_ny, w_b_nz, w_b_d, w_b_i} = w_mid_out;

    sdp_queue #(
        .WIDTH (MID_W),
        .DEPTH (4)
    ) u_mid_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_mid_push),
        .i_data  (w_mid_in),
        .o_full  (w_mid_full),
        .i_pop   (w_mid_pop),
        .o_data  (w_mid_out),
        .o_empty (w_mid_empty)
    );

    // The divider pipeline moves whenever the result queue has room.
    assign w_back_en = !w_out_full;
    assign w_mid_pop = w_back_en && !w_mid_empty;

    sdp_back #(
        .NUM_W (NUM_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_back_en),
        .i_valid     (!w_mid_empty),
        .i_flags     (w_b_flags),
        .i_num_x     (w_b_nx),
        .i_num_y     (w_b_ny),
        .i_num_z     (w_b_nz),
        .i_disp      (w_b_d),
        .i_intensity (w_b_i),
        .o_valid     (w_back_valid),
        .o_point     (w_back_point)
    );

    // Result queue.
    sdp_queue #(
        .WIDTH ($bits(t_point)),
        .DEPTH (2)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_back_en && w_back_valid),
        .i_data  (w_back_point),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_data  (w_head),
        .o_empty (empty)
    );

    assign o_point_x         = w_head.x;
    assign o_point_y         = w_head.y;
    assign o_point_z         = w_head.z;
    assign o_point_intensity = w_head.intensity;
    assign o_depth_valid     = w_head.depth_valid;

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_depth_valid) |-> (o_point_x == '0 && o_point_y == '0 && o_point_z == '0))
        else $error("invalid depth with nonzero coordinates");
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> empty)
        else $error("results present right after reset");
    a_mid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mid_push && w_mid_full) |=> (w_mid_push && $stable(w_mid_in)))
        else $error("front end changed a word waiting for the work queue");

endmodule

>>> tb/stereo_disparity_to_point_tb.sv
// Self-checking testbench for stereo_disparity_to_point.
// Depends on sdp_pkg and the block's RTL; a small scoreboard predicts each point.
`timescale 1ns / 100ps

module stereo_disparity_to_point_tb;
    import sdp_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 48;

    // Scoreboard: holds a copy of the registers and the points still owed.
    class point_board;
        logic [CTR_W-1:0]   ctr_x, ctr_y;
        logic [FOCAL_W-1:0] focal;
        logic [BASE_W-1:0]  baseline;
        logic [SIZE_W-1:0]  width, height;
        logic               calibrated;
        logic [1:0]         decim;
        t_point             owed_points[$];
        int                 errors;

        function new();
            ctr_x = RST_CENTER_X;
            ctr_y = RST_CENTER_Y;
            focal = RST_FOCAL;
            baseline = RST_BASELINE;
            width = RST_WIDTH;
            height = RST_HEIGHT;
            calibrated = 1'b0;
            decim = RST_DECIM;
            errors = 0;
        endfunction

        // Signed offset times baseline over disparity, truncated and saturated.
        function logic [XY_W-1:0] offset_coord(logic [63:0] pos_q4, logic [63:0] ctr_q4,
                                               logic [63:0] den);
            logic        neg;
            logic [63:0] mag, q;
            neg = pos_q4 < ctr_q4;
            mag = neg ? ctr_q4 - pos_q4 : pos_q4 - ctr_q4;
            q = ((mag * baseline) << 4) / den;
            if (neg) begin
                if (q > 64'(NEG_MAX)) q = 64'(NEG_MAX);
                return XY_W'(64'd0 - q);
            end
            if (q > 64'(POS_MAX)) q = 64'(POS_MAX);
            return q[XY_W-1:0];
        endfunction

        // Work out the point an accepted pixel should produce, if any.
        function void note_pixel(logic [11:0] u, logic [11:0] v, logic [11:0] d,
                                 logic [11:0] inten);
            t_point      pt;
            logic [63:0] den, z;
            logic [12:0] step_mask;
            step_mask = (13'd1 << decim) - 13'd1;
            if (!calibrated) return;
            if ({1'b0, u} >= width || {1'b0, v} >= height) return;
            if (((width - 13'd1 - {1'b0, u}) & step_mask) != 0) return;
            if (((height - 13'd1 - {1'b0, v}) & step_mask) != 0) return;
            pt = '0;
            pt.intensity = inten;
            if (d != 0) begin
                den = 64'(d) << DEN_SHIFT;
                z = ((64'(baseline) * 64'(focal)) << 4) / den;
                if (z > 64'(POS_MAX)) z = 64'(POS_MAX);
                pt.x = offset_coord(64'(u) << 4, 64'(ctr_x), den);
                pt.y = offset_coord(64'(v) << 4, 64'(ctr_y), den);
                pt.z = z[Z_W-1:0];
                pt.depth_valid = 1'b1;
            end
            owed_points = {owed_points, pt};
        endfunction

        // Compare one popped word with the oldest owed point.
        function void check_point(t_point got);
            t_point want;
            if (owed_points.size() == 0) begin
                $display("%0t: unexpected point x=%h y=%h z=%h", $time, got.x, got.y, got.z);
                errors++;
                return;
            end
            want = owed_points.pop_front();
            if (got.x !== want.x) begin
                $display("%0t: point_x expected %h actual %h", $time, want.x, got.x);
                errors++;
            end
            if (got.y !== want.y) begin
                $display("%0t: point_y expected %h actual %h", $time, want.y, got.y);
                errors++;
            end
            if (got.z !== want.z) begin
                $display("%0t: point_z expected %h actual %h", $time, want.z, got.z);
                errors++;
            end
            if (got.intensity !== want.intensity) begin
                $display("%0t: point_intensity expected %h actual %h", $time,
                         want.intensity, got.intensity);
                errors++;
            end
            if (got.depth_valid !== want.depth_valid) begin
                $display("%0t: depth_valid expected %b actual %b", $time,
                         want.depth_valid, got.depth_valid);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  push = 1'b0;
    logic                  full;
    logic [11:0]           i_column = '0;
    logic [11:0]           i_row = '0;
    logic [DISP_W-1:0]     i_disparity = '0;
    logic [INTEN_W-1:0]    i_intensity = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [XY_W-1:0]       o_point_x, o_point_y;
    logic [Z_W-1:0]        o_point_z;
    logic [INTEN_W-1:0]    o_point_intensity;
    logic                  o_depth_valid;

    point_board board;
    int         idle_pct = 38;
    bit         hold_req = 1'b0;
    int         hold_cnt = 0;
    int         quiet_cycles = 0;

    stereo_disparity_to_point u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .push              (push),
        .full              (full),
        .i_column          (i_column),
        .i_row             (i_row),
        .i_disparity       (i_disparity),
        .i_intensity       (i_intensity),
        .empty             (empty),
        .pop               (pop),
        .o_point_x         (o_point_x),
        .o_point_y         (o_point_y),
        .o_point_z         (o_point_z),
        .o_point_intensity (o_point_intensity),
        .o_depth_valid     (o_depth_valid)
    );

    always #10 i_clk = ~i_clk;

    // Receiver: random pops, with a long hold-off on request.
    initial begin
        board = new();
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_cnt = 400;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    // Result monitor and watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            board.check_point('{o_point_x, o_point_y, o_point_z, o_point_intensity,
                                o_depth_valid});
        if ((push && !full) || (pop && !empty) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Write one register with junk above its width, which the block must mask.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value,
                             int width);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom) & ~((CFG_DATA_W'(1) << width) - CFG_DATA_W'(1));
        if (width >= CFG_DATA_W) junk = '0;
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value | junk;
        @(posedge i_clk);
    endtask

    // Load every register and mirror it in the scoreboard; block must be idle.
    task automatic load_setup(logic [15:0] cx, logic [15:0] cy, logic [15:0] f,
                              logic [19:0] b, logic [12:0] w, logic [12:0] h,
                              logic cal, logic [1:0] sh);
        write_reg(REG_CENTER_X, 20'(cx), CTR_W);
        write_reg(REG_CENTER_Y, 20'(cy), CTR_W);
        write_reg(REG_FOCAL, 20'(f), FOCAL_W);
        write_reg(REG_BASELINE, b, BASE_W);
        write_reg(REG_WIDTH, 20'(w), SIZE_W);
        write_reg(REG_HEIGHT, 20'(h), SIZE_W);
        write_reg(REG_CALIBRATED, 20'(cal), 1);
        write_reg(REG_DECIMATION, 20'(sh), 2);
        i_cfg_wr_en <= 1'b0;
        board.ctr_x = cx;
        board.ctr_y = cy;
        board.focal = f;
        board.baseline = b;
        board.width = w;
        board.height = h;
        board.calibrated = cal;
        board.decim = sh;
    endtask

    // Offer one pixel word, with random idle cycles ahead of it.
    task automatic send_pixel(logic [11:0] u, logic [11:0] v, logic [11:0] d,
                              logic [11:0] inten);
        if ($urandom_range(99) < idle_pct) begin
            push <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        push        <= 1'b1;
        i_column    <= u;
        i_row       <= v;
        i_disparity <= d;
        i_intensity <= inten;
        do @(posedge i_clk); while (full);
        board.note_pixel(u, v, d, inten);
    endtask

    // Stop offering, wait for every owed point, then let dropped words flush.
    task automatic drain();
        push <= 1'b0;
        do @(posedge i_clk); while (board.owed_points.size() > 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Random pixel: mostly on the grid of the current setup, the rest noise.
    task automatic random_pixel();
        logic [11:0] u, v, d;
        int          step;
        step = 1 << board.decim;
        if ($urandom_range(99) < 80) begin
            u = 12'(board.width - 1 - step * $urandom_range((board.width - 1) >> board.decim));
            v = 12'(board.height - 1 - step * $urandom_range((board.height - 1) >> board.decim));
        end else begin
            u = 12'($urandom);
            v = 12'($urandom);
        end
        case ($urandom_range(9))
            0: d = '0;
            1, 2: d = 12'($urandom_range(15) + 1);
            default: d = 12'($urandom);
        endcase
        send_pixel(u, v, d, 12'($urandom));
    endtask

    // Main sequence: directed setups, then random setups.
    initial begin
        logic [12:0] w, h;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Not calibrated after reset: nothing should come out.
        send_pixel(12'd639, 12'd479, 12'd16, 12'd7);
        send_pixel(12'd3, 12'd3, 12'd100, 12'd8);
        drain();

        // Default camera, calibrated: corners, zero and full disparity, rejects.
        load_setup(16'd5075, 16'd3733, 16'd4920, 20'd36543, 13'd640, 13'd480, 1'b1, 2'd2);
        send_pixel(12'd639, 12'd479, 12'd1, 12'd0);
        send_pixel(12'd639, 12'd479, 12'd4095, 12'd4095);
        send_pixel(12'd3, 12'd3, 12'd64, 12'd100);
        send_pixel(12'd315, 12'd231, 12'd0, 12'd55);
        send_pixel(12'd640, 12'd479, 12'd64, 12'd1);
        send_pixel(12'd639, 12'd480, 12'd64, 12'd2);
        send_pixel(12'd638, 12'd479, 12'd64, 12'd3);
        send_pixel(12'd639, 12'd477, 12'd64, 12'd4);
        send_pixel(12'd4095, 12'd4095, 12'd4095, 12'd4095);
        drain();

        // Largest image, baseline and focal, center at zero, full resolution.
        load_setup(16'd0, 16'd0, 16'hFFFF, 20'hFFFFF, 13'd4096, 13'd4096, 1'b1, 2'd0);
        send_pixel(12'd4095, 12'd4095, 12'd1, 12'd9);
        send_pixel(12'd0, 12'd0, 12'd1, 12'd10);
        send_pixel(12'd2048, 12'd1, 12'd4095, 12'd11);
        send_pixel(12'd4095, 12'd0, 12'd0, 12'd12);
        drain();

        // Zero focal, center at maximum, one-pixel image, coarsest grid.
        load_setup(16'hFFFF, 16'hFFFF, 16'd0, 20'hFFFFF, 13'd1, 13'd1, 1'b1, 2'd3);
        send_pixel(12'd0, 12'd0, 12'd1, 12'd13);
        send_pixel(12'd0, 12'd0, 12'd2048, 12'd14);
        send_pixel(12'd1, 12'd0, 12'd1, 12'd15);
        send_pixel(12'd0, 12'd0, 12'd0, 12'd16);
        drain();

        // Random setups; one runs without idling, one with a receiver hold-off.
        for (int phase = 0; phase < 8; phase++) begin
            w = (phase % 3 == 0) ? 13'($urandom_range(4096, 1)) : 13'($urandom_range(64, 1));
            h = (phase % 3 == 1) ? 13'($urandom_range(4096, 1)) : 13'($urandom_range(64, 1));
            load_setup(16'($urandom), 16'($urandom), 16'($urandom), 20'($urandom),
                       w, h, (phase != 5), 2'($urandom));
            idle_pct = (phase == 2) ? 0 : 38;
            if (phase == 4) hold_req = 1'b1;
            for (int n = 0; n < 135; n++) random_pixel();
            drain();
        end
        idle_pct = 38;

        if (board.errors == 0 && board.owed_points.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
